/* hdl/cramer_pkg.sv */
// Shared widths, saturation limits and product helpers for the 3x3 Cramer solver.
`timescale 1ns / 1ps
package cramer_pkg;

  localparam int CW    = 16;          // coefficient width
  localparam int OFB   = 16;          // output fraction bits
  localparam int NCOEF = 12;          // coefficients per item
  localparam int PW    = 2 * CW;      // 2x2 product
  localparam int CFW   = PW + 1;      // cofactor
  localparam int TW    = CFW + CW;    // cofactor times coefficient
  localparam int SW    = TW + 2;      // sum of three terms
  localparam int NW    = SW + OFB;    // scaled numerator magnitude
  localparam int QW    = 33;          // quotient bits kept
  localparam int RW    = SW + 1;      // divider partial remainder
  localparam int OW    = 32;          // solution width
  localparam int IDW   = NCOEF * CW;  // input tdata width
  localparam int ODW   = 3 * OW;      // output tdata width

  localparam logic [QW-1:0] SAT_POS = QW'(33'h0_7FFF_FFFF);
  localparam logic [QW-1:0] SAT_NEG = QW'(33'h0_8000_0000);

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [NW-1:0] num;
    logic [QW-1:0] quo;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic          sing;
    logic [SW-1:0] den;
    lane_t [2:0]   ln;
  } dstg_t;

  function automatic logic signed [PW-1:0] mul_cc(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
    mul_cc = a * b;
  endfunction

  function automatic logic signed [TW-1:0] mul_fc(input logic signed [CFW-1:0] a,
                                                  input logic signed [CW-1:0] b);
    mul_fc = a * b;
  endfunction

endpackage

/* hdl/cramer_3x3_solver.sv */
// Top level: pipelined 3x3 linear system solver by Cramer's rule.
`timescale 1ns / 1ps
// Usage
//   Input channel in_*: one item is one system, nine Q8.8 coefficients and
//   three Q8.8 right-hand sides packed in in_tdata (m11 in the lowest bits).
//   Output channel out_*: one item per input item, x, y, z as Q16.16 in
//   out_tdata, singular and overflow flags in out_tuser.
//   Throughput: one item per cycle, sustained while out_tready stays high.
//   Pipeline: products, cofactors, products, sums, magnitudes, then a
//   34-stage restoring divider (range check plus one quotient bit per
//   stage, three lanes side by side) sets the depth.
//   A zero determinant gives zero solutions and singular; a quotient out of
//   32-bit range saturates and raises overflow.
//   Reset (rst_n low, synchronous) empties the pipeline and output buffers;
//   in_tready is held low while rst_n is low.
//   When out_tready is low the result waits in the output register and one
//   more item is caught in a skid register; then in_tready drops and the
//   whole pipeline holds, losing and repeating nothing.
module cramer_3x3_solver (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // m11 m12 m13 m21 m22 m23 m31 m32 m33 rhs1 rhs2 rhs3, 16 bits each
  input  logic [cramer_pkg::IDW-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // sol_x sol_y sol_z, 32 bits each
  output logic [cramer_pkg::ODW-1:0] out_tdata,
  // singular, overflow
  output logic [1:0]              out_tuser
);
  import cramer_pkg::*;

  logic en;

  // unpacked input
  logic signed [CW-1:0] m   [9];
  logic signed [CW-1:0] rhs [3];

  always_comb begin
    for (int i = 0; i < 9; i++) m[i] = in_tdata[i*CW +: CW];
    for (int r = 0; r < 3; r++) rhs[r] = in_tdata[(9+r)*CW +: CW];
  end

  // stage 1: 2x2 products
  logic                 s1_vld_r;
  logic signed [PW-1:0] s1_pa_r  [9];
  logic signed [PW-1:0] s1_pb_r  [9];
  logic signed [CW-1:0] s1_rhs_r [3];
  logic signed [CW-1:0] s1_col_r [3];

  // stage 2: cofactors, index 3*lane+row (lanes x, y, z)
  logic                  s2_vld_r;
  logic signed [CFW-1:0] s2_cof_r [9];
  logic signed [CW-1:0]  s2_rhs_r [3];
  logic signed [CW-1:0]  s2_col_r [3];

  // stage 3: terms, lanes 0..2 numerators, lane 3 determinant
  logic                 s3_vld_r;
  logic signed [TW-1:0] s3_t_r [12];

  // stage 4: sums
  logic                 s4_vld_r;
  logic signed [SW-1:0] s4_sum_r [4];

  // stage 5: magnitudes and signs
  logic          s5_vld_r;
  logic          s5_sing_r;
  logic [SW-1:0] s5_den_r;
  logic [SW-1:0] s5_mag_r [3];
  logic          s5_neg_r [3];

  // divider stages
  logic  dv_vld_r [QW+1];
  dstg_t dv_r     [QW+1];
  dstg_t dv_nxt   [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // x cofactors
      s1_pa_r[0] <= mul_cc(m[4], m[8]); s1_pb_r[0] <= mul_cc(m[5], m[7]);
      s1_pa_r[1] <= mul_cc(m[2], m[7]); s1_pb_r[1] <= mul_cc(m[1], m[8]);
      s1_pa_r[2] <= mul_cc(m[1], m[5]); s1_pb_r[2] <= mul_cc(m[2], m[4]);
      // y cofactors
      s1_pa_r[3] <= mul_cc(m[5], m[6]); s1_pb_r[3] <= mul_cc(m[3], m[8]);
      s1_pa_r[4] <= mul_cc(m[0], m[8]); s1_pb_r[4] <= mul_cc(m[2], m[6]);
      s1_pa_r[5] <= mul_cc(m[2], m[3]); s1_pb_r[5] <= mul_cc(m[0], m[5]);
      // z cofactors
      s1_pa_r[6] <= mul_cc(m[3], m[7]); s1_pb_r[6] <= mul_cc(m[4], m[6]);
      s1_pa_r[7] <= mul_cc(m[1], m[6]); s1_pb_r[7] <= mul_cc(m[0], m[7]);
      s1_pa_r[8] <= mul_cc(m[0], m[4]); s1_pb_r[8] <= mul_cc(m[1], m[3]);
      for (int r = 0; r < 3; r++) begin
        s1_rhs_r[r] <= rhs[r];
        s1_col_r[r] <= m[3*r];
      end

      for (int j = 0; j < 9; j++) s2_cof_r[j] <= CFW'(s1_pa_r[j]) - CFW'(s1_pb_r[j]);
      s2_rhs_r <= s1_rhs_r;
      s2_col_r <= s1_col_r;

      for (int l = 0; l < 3; l++)
        for (int r = 0; r < 3; r++)
          s3_t_r[3*l+r] <= mul_fc(s2_cof_r[3*l+r], s2_rhs_r[r]);
      // determinant: expansion along column 1 using the x cofactors
      for (int r = 0; r < 3; r++) s3_t_r[9+r] <= mul_fc(s2_cof_r[r], s2_col_r[r]);

      for (int l = 0; l < 4; l++)
        s4_sum_r[l] <= SW'(s3_t_r[3*l]) + SW'(s3_t_r[3*l+1]) + SW'(s3_t_r[3*l+2]);

      s5_sing_r <= (s4_sum_r[3] == '0);
      s5_den_r  <= s4_sum_r[3][SW-1] ? SW'(-s4_sum_r[3]) : SW'(s4_sum_r[3]);
      for (int l = 0; l < 3; l++) begin
        s5_mag_r[l] <= s4_sum_r[l][SW-1] ? SW'(-s4_sum_r[l]) : SW'(s4_sum_r[l]);
        s5_neg_r[l] <= s4_sum_r[l][SW-1] ^ s4_sum_r[3][SW-1];
      end
    end
  end

  // divider entry: scale numerator, check quotient fits in QW bits
  always_comb begin
    dv_nxt[0].sing = s5_sing_r;
    dv_nxt[0].den  = s5_den_r;
    for (int l = 0; l < 3; l++) begin
      dv_nxt[0].ln[l].num = {s5_mag_r[l], {OFB{1'b0}}};
      dv_nxt[0].ln[l].rem = RW'(dv_nxt[0].ln[l].num[NW-1:QW]);
      dv_nxt[0].ln[l].quo = '0;
      dv_nxt[0].ln[l].ovf = (dv_nxt[0].ln[l].rem >= RW'(s5_den_r));
      dv_nxt[0].ln[l].neg = s5_neg_r[l];
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_comb begin
      logic [RW-1:0] rs;
      logic          ge;
      dv_nxt[k] = dv_r[k-1];
      for (int l = 0; l < 3; l++) begin
        rs = {dv_r[k-1].ln[l].rem[RW-2:0], dv_r[k-1].ln[l].num[QW-k]};
        ge = (rs >= RW'(dv_r[k-1].den));
        dv_nxt[k].ln[l].rem = ge ? rs - RW'(dv_r[k-1].den) : rs;
        dv_nxt[k].ln[l].quo[QW-k] = ge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) dv_vld_r[k] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= s5_vld_r;
      for (int k = 1; k <= QW; k++) dv_vld_r[k] <= dv_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QW; k++) dv_r[k] <= dv_nxt[k];
    end
  end

  // saturation and sign on the divider tail
  logic [ODW-1:0] res_data;
  logic [1:0]     res_user;

  always_comb begin
    logic [QW-1:0] lim;
    logic          sat;
    logic          any_sat;
    any_sat  = 1'b0;
    res_data = '0;
    for (int l = 0; l < 3; l++) begin
      lim = dv_r[QW].ln[l].neg ? SAT_NEG : SAT_POS;
      sat = dv_r[QW].ln[l].ovf || (dv_r[QW].ln[l].quo > lim);
      any_sat = any_sat | sat;
      if (!dv_r[QW].sing) begin
        if (sat)
          res_data[l*OW +: OW] = lim[OW-1:0];
        else if (dv_r[QW].ln[l].neg)
          res_data[l*OW +: OW] = OW'(-dv_r[QW].ln[l].quo[OW-1:0]);
        else
          res_data[l*OW +: OW] = dv_r[QW].ln[l].quo[OW-1:0];
      end
    end
    res_user = {any_sat & ~dv_r[QW].sing, dv_r[QW].sing};
  end

  // output register plus skid register
  logic           out_vld_r, skid_vld_r;
  logic [ODW-1:0] out_data_r, skid_data_r;
  logic [1:0]     out_user_r, skid_user_r;
  logic           push, pop;

  assign en        = !skid_vld_r;
  assign in_tready = en && rst_n;
  assign push      = en && dv_vld_r[QW];
  assign pop       = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
      end
    end else if (push) begin
      if (out_vld_r) skid_vld_r <= 1'b1;
      else           out_vld_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_vld_r) begin
      out_data_r <= skid_data_r;
      out_user_r <= skid_user_r;
    end else if (push && (pop || !out_vld_r)) begin
      out_data_r <= res_data;
      out_user_r <= res_user;
    end
    if (push && out_vld_r && !pop) begin
      skid_data_r <= res_data;
      skid_user_r <= res_user;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* hdl/cramer_chk.sv */
// Port-level checker for the 3x3 Cramer solver and its bind.
`timescale 1ns / 1ps
module cramer_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_tvalid,
  input logic                    out_tready,
  input logic [cramer_pkg::ODW-1:0] out_tdata,
  input logic [1:0]              out_tuser
);
  import cramer_pkg::*;

  a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  a_singular_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("singular item with nonzero solution or overflow");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind cramer_3x3_solver cramer_chk u_cramer_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
